// ===== hdl/context_load_forward_dead_store_table_top_assert.svh =====
// Assertion macros shared by the checker of the context load forwarding block.
// Depends on nothing; the including module must provide i_clk and i_rst_n.
`ifndef CONTEXT_LOAD_FORWARD_DEAD_STORE_TABLE_TOP_ASSERT_SVH
`define CONTEXT_LOAD_FORWARD_DEAD_STORE_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CLFDST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CLFDST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/clfdst_pkg.sv =====
// Package of the context load forwarding and dead store block.
// Holds widths, codes, the controller state type and the command structs.
package clfdst_pkg;

    // Defaults of the top-level parameters.
    localparam int CONTEXT_BYTES_DEF = 4096;
    localparam int VALUE_ID_BITS_DEF = 16;

    // Fixed field widths of the item and result ports.
    localparam int OFFSET_W = 12;
    localparam int ID_W     = 16;
    localparam int OP_W     = 2;

    // Width of the flush generation tag kept per table entry.
    localparam int EPOCH_BITS = 8;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_PASS_MODE = '0;

    // Instruction classes.
    localparam logic [OP_W-1:0] OP_OTHER = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_STORE = 2'd2;

    // Pass modes.
    localparam logic MODE_FWD = 1'b0;
    localparam logic MODE_BWD = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;        // capture the accepted item
        logic epoch_inc;    // flush by moving to the next tag
        logic epoch_one;    // restart tags at one after a sweep
        logic sweep_start;  // restart the sweep counter
        logic sweep_write;  // clear one tag entry
        logic mem_read;     // read both tables at the item offset
        logic commit;       // update tables and load the result
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic flush_req;    // the item at the input flushes the table
        logic epoch_max;    // the tag counter has no room for another flush
        logic sweep_last;   // the sweep is at its last entry
    } t_dp_status;

endpackage

// ===== hdl/clfdst_regs.sv =====
// Configuration register file on an APB-style port.
// Depends on clfdst_pkg for address and data widths.
module clfdst_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [clfdst_pkg::PADDR_W-1:0]    paddr,
    input  logic [clfdst_pkg::PDATA_W-1:0]    pwdata,
    output logic [clfdst_pkg::PDATA_W-1:0]    prdata,
    output logic                              pready,
    output logic                              o_pass_mode
);

    logic r_pass_mode;
    logic n_pass_mode;
    logic sel_mode;

    // Word index decode; the low two address bits select bytes only.
    assign sel_mode = (paddr[clfdst_pkg::PADDR_W-1:2] == clfdst_pkg::REG_PASS_MODE);

    always_comb begin
        n_pass_mode = r_pass_mode;
        if (psel && penable && pwrite && sel_mode) begin
            n_pass_mode = pwdata[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pass_mode <= clfdst_pkg::MODE_FWD;
        end else begin
            r_pass_mode <= n_pass_mode;
        end
    end

    // Reads return the register, other words read as zero.
    assign prdata      = sel_mode ? {{(clfdst_pkg::PDATA_W-1){1'b0}}, r_pass_mode} : '0;
    assign pready      = 1'b1;
    assign o_pass_mode = r_pass_mode;

endmodule

// ===== hdl/clfdst_ctrl.sv =====
// Controller state machine: item handshake, tag sweep and result register valid.
// Depends on clfdst_pkg for the state type and the command structs.
module clfdst_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    input  clfdst_pkg::t_dp_status  i_status,
    output clfdst_pkg::t_dp_cmd     o_cmd
);

    clfdst_pkg::t_state r_state;
    clfdst_pkg::t_state n_state;
    logic               r_pending;
    logic               n_pending;
    logic               r_out_valid;
    logic               n_out_valid;
    logic               accept;
    logic               out_free;
    logic               wrap;

    assign accept   = (r_state == clfdst_pkg::S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;
    assign wrap     = i_status.flush_req && i_status.epoch_max;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            clfdst_pkg::S_CLEAR: begin
                if (i_status.sweep_last) begin
                    n_state = r_pending ? clfdst_pkg::S_READ : clfdst_pkg::S_IDLE;
                end
            end
            clfdst_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = wrap ? clfdst_pkg::S_CLEAR : clfdst_pkg::S_READ;
                end
            end
            clfdst_pkg::S_READ: begin
                n_state = clfdst_pkg::S_EXEC;
            end
            clfdst_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = clfdst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clfdst_pkg::S_CLEAR;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            clfdst_pkg::S_CLEAR: begin
                o_cmd.sweep_write = 1'b1;
                o_cmd.epoch_one   = i_status.sweep_last;
            end
            clfdst_pkg::S_IDLE: begin
                o_cmd.latch       = accept;
                o_cmd.epoch_inc   = accept && i_status.flush_req && !i_status.epoch_max;
                o_cmd.sweep_start = accept && wrap;
            end
            clfdst_pkg::S_READ: begin
                o_cmd.mem_read = 1'b1;
            end
            clfdst_pkg::S_EXEC: begin
                o_cmd.commit = out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // An item waiting behind a sweep, and the result register's valid.
    always_comb begin
        n_pending = r_pending;
        if (o_cmd.sweep_start) begin
            n_pending = 1'b1;
        end else if ((r_state == clfdst_pkg::S_CLEAR) && i_status.sweep_last) begin
            n_pending = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= clfdst_pkg::S_CLEAR;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == clfdst_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/clfdst_dp.sv =====
// Datapath: item registers, tag and value memories, flush tag counter, result registers.
// Depends on clfdst_pkg for widths, codes and the command structs.
module clfdst_dp #(
    parameter int CONTEXT_BYTES = clfdst_pkg::CONTEXT_BYTES_DEF,
    parameter int VALUE_ID_BITS = clfdst_pkg::VALUE_ID_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pass_mode,
    input  logic                               i_block_first,
    input  logic [clfdst_pkg::OP_W-1:0]        i_op,
    input  logic                               i_is_volatile,
    input  logic                               i_is_branch,
    input  logic [clfdst_pkg::OFFSET_W-1:0]    i_offset,
    input  logic [clfdst_pkg::ID_W-1:0]        i_value_id,
    input  clfdst_pkg::t_dp_cmd                i_cmd,
    output clfdst_pkg::t_dp_status             o_status,
    output logic                               o_replace_load,
    output logic [clfdst_pkg::ID_W-1:0]        o_forward_id,
    output logic                               o_store_dead
);

    localparam int ADDR_W = (CONTEXT_BYTES > 1) ? $clog2(CONTEXT_BYTES) : 1;
    localparam int CMP_W  = ((ADDR_W > clfdst_pkg::OFFSET_W) ? ADDR_W
                                                             : clfdst_pkg::OFFSET_W) + 2;
    localparam int EW     = clfdst_pkg::EPOCH_BITS;

    // Tag memory: an entry is valid when its tag equals the current tag.
    logic [EW-1:0]            tag_mem [CONTEXT_BYTES];
    logic [VALUE_ID_BITS-1:0] val_mem [CONTEXT_BYTES];

    logic [clfdst_pkg::OP_W-1:0]     r_op;
    logic                            r_volatile;
    logic                            r_branch;
    logic [clfdst_pkg::OFFSET_W-1:0] r_offset;
    logic [clfdst_pkg::ID_W-1:0]     r_value_id;
    logic [EW-1:0]                   r_epoch;
    logic [EW-1:0]                   n_epoch;
    logic [ADDR_W-1:0]               r_sweep;
    logic [ADDR_W-1:0]               n_sweep;
    logic [EW-1:0]                   r_rd_tag;
    logic [VALUE_ID_BITS-1:0]        r_rd_val;
    logic                            r_replace;
    logic [clfdst_pkg::ID_W-1:0]     r_fwd_id;
    logic                            r_dead;

    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic              hit;
    logic              fwd_act;
    logic              bwd_act;
    logic              tag_we;
    logic              val_we;
    logic              res_replace;
    logic              res_dead;

    assign o_status.flush_req  = i_block_first || i_is_volatile
                                 || ((i_pass_mode == clfdst_pkg::MODE_BWD) && i_is_branch);
    assign o_status.epoch_max  = (r_epoch == {EW{1'b1}});
    assign o_status.sweep_last = (r_sweep == ADDR_W'(CONTEXT_BYTES - 1));

    // Capture the accepted item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op       <= i_op;
            r_volatile <= i_is_volatile;
            r_branch   <= i_is_branch;
            r_offset   <= i_offset;
            r_value_id <= i_value_id;
        end
    end

    // Flush tag and sweep counter.
    always_comb begin
        n_epoch = r_epoch;
        if (i_cmd.epoch_one) begin
            n_epoch = EW'(1);
        end else if (i_cmd.epoch_inc) begin
            n_epoch = r_epoch + EW'(1);
        end
        n_sweep = r_sweep;
        if (i_cmd.sweep_start) begin
            n_sweep = '0;
        end else if (i_cmd.sweep_write && !o_status.sweep_last) begin
            n_sweep = r_sweep + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EW'(1);
            r_sweep <= '0;
        end else begin
            r_epoch <= n_epoch;
            r_sweep <= n_sweep;
        end
    end

    // Table lookup and update decisions for the held item.
    assign in_range = (CMP_W'(r_offset) < CMP_W'(CONTEXT_BYTES));
    assign addr     = ADDR_W'(r_offset);
    assign hit      = (r_rd_tag == r_epoch);
    assign fwd_act  = (i_pass_mode == clfdst_pkg::MODE_FWD) && !r_volatile && in_range;
    assign bwd_act  = (i_pass_mode == clfdst_pkg::MODE_BWD) && !r_volatile && !r_branch
                      && in_range && (r_op == clfdst_pkg::OP_STORE);

    always_comb begin
        res_replace = 1'b0;
        res_dead    = 1'b0;
        val_we      = 1'b0;
        tag_we      = 1'b0;
        if (fwd_act && (r_op == clfdst_pkg::OP_LOAD)) begin
            res_replace = hit;
            val_we      = !hit;
            tag_we      = !hit;
        end else if (fwd_act && (r_op == clfdst_pkg::OP_STORE)) begin
            val_we = 1'b1;
            tag_we = 1'b1;
        end else if (bwd_act) begin
            res_dead = hit;
            tag_we   = !hit;
        end
    end

    // Tag memory: swept to zero, written at commit, read into a register before the compare.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_write) begin
            tag_mem[r_sweep] <= '0;
        end else if (i_cmd.commit && tag_we) begin
            tag_mem[addr] <= r_epoch;
        end
        if (i_cmd.mem_read && in_range) begin
            r_rd_tag <= tag_mem[addr];
        end
    end

    // Value memory: masked to the id width, read alongside the tag.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && val_we) begin
            val_mem[addr] <= VALUE_ID_BITS'(r_value_id);
        end
        if (i_cmd.mem_read && in_range) begin
            r_rd_val <= val_mem[addr];
        end
    end

    // Result registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_replace <= res_replace;
            r_fwd_id  <= res_replace ? clfdst_pkg::ID_W'(r_rd_val) : '0;
            r_dead    <= res_dead;
        end
    end

    assign o_replace_load = r_replace;
    assign o_forward_id   = r_fwd_id;
    assign o_store_dead   = r_dead;

endmodule

// ===== hdl/context_load_forward_dead_store_table_top.sv =====
// Context load forwarding and dead store table: one instruction descriptor in, one
// result out per item. An item is accepted, the per-offset tag and value memories are
// read into registers, and the compare and update then load the result; a full result
// register holds the next item in its update cycle until the result is taken. Flushes
// (block start, volatile, backward-mode branch) bump an 8-bit tag instead of clearing
// valid bits; on every 255th flush, and after reset, the tag memory is swept to zero,
// and no item is accepted during the sweep. Configuration writes are taken at any time.
module context_load_forward_dead_store_table_top #(
    parameter int CONTEXT_BYTES = clfdst_pkg::CONTEXT_BYTES_DEF,
    parameter int VALUE_ID_BITS = clfdst_pkg::VALUE_ID_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [clfdst_pkg::PADDR_W-1:0]     paddr,
    input  logic [clfdst_pkg::PDATA_W-1:0]     pwdata,
    output logic [clfdst_pkg::PDATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_block_first,
    input  logic [clfdst_pkg::OP_W-1:0]        i_op,
    input  logic                               i_is_volatile,
    input  logic                               i_is_branch,
    input  logic [clfdst_pkg::OFFSET_W-1:0]    i_offset,
    input  logic [clfdst_pkg::ID_W-1:0]        i_value_id,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_replace_load,
    output logic [clfdst_pkg::ID_W-1:0]        o_forward_id,
    output logic                               o_store_dead
);

    logic                   pass_mode;
    clfdst_pkg::t_dp_cmd    cmd;
    clfdst_pkg::t_dp_status status;

    // Configuration registers.
    clfdst_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_pass_mode (pass_mode)
    );

    // Sequencing of items and sweeps.
    clfdst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Tables and result computation.
    clfdst_dp #(
        .CONTEXT_BYTES (CONTEXT_BYTES),
        .VALUE_ID_BITS (VALUE_ID_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pass_mode    (pass_mode),
        .i_block_first  (i_block_first),
        .i_op           (i_op),
        .i_is_volatile  (i_is_volatile),
        .i_is_branch    (i_is_branch),
        .i_offset       (i_offset),
        .i_value_id     (i_value_id),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_replace_load (o_replace_load),
        .o_forward_id   (o_forward_id),
        .o_store_dead   (o_store_dead)
    );

endmodule

// ===== hdl/clfdst_checker.sv =====
// Port-level checker for the context load forwarding block, bound to the top level.
// Depends on clfdst_pkg and the assertion macro header.
`include "context_load_forward_dead_store_table_top_assert.svh"

module clfdst_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            pready,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_replace_load,
    input logic [clfdst_pkg::ID_W-1:0]     o_forward_id,
    input logic                            o_store_dead
);

    // A waiting result keeps its value until taken.
    `CLFDST_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_forward_id) && $stable(o_replace_load) && $stable(o_store_dead), "result changed while stalled")

    // A load is never both forwarded and a dead store.
    `CLFDST_ASSERT_NOW(a_excl, o_out_valid, !(o_replace_load && o_store_dead), "replace and dead both set")

    // The forwarded id is zero unless the load is replaced.
    `CLFDST_ASSERT_NOW(a_fwd_zero, o_out_valid && !o_replace_load, o_forward_id == '0, "forward id not zero")

    // One item at a time: an accepted item closes the input for the next cycle.
    `CLFDST_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready && pready, "input reopened too early")

endmodule

bind context_load_forward_dead_store_table_top clfdst_checker u_clfdst_checker (.*);

// ===== bench/tb_context_load_forward_dead_store_table_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the context load forwarding and dead store table.
// Depends on clfdst_pkg and on context_load_forward_dead_store_table_top only.
module tb_context_load_forward_dead_store_table_top;
    import clfdst_pkg::*;

    localparam int CTX_BYTES     = CONTEXT_BYTES_DEF;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int MAX_REPORTS   = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic [OP_W-1:0]    OP_UNUSED      = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_PASS_MODE = {REG_PASS_MODE, 2'b00};

    // One expected result item.
    typedef struct packed {
        logic            replace_load;
        logic [ID_W-1:0] forward_id;
        logic            store_dead;
    } t_verdict;

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_block_first;
    logic [OP_W-1:0]     i_op;
    logic                i_is_volatile;
    logic                i_is_branch;
    logic [OFFSET_W-1:0] i_offset;
    logic [ID_W-1:0]     i_value_id;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_replace_load;
    logic [ID_W-1:0]     o_forward_id;
    logic                o_store_dead;

    // Shadow copy of the offset table: live bit, recorded id, and whether an id was
    // ever recorded at that offset.
    bit              slot_live  [CTX_BYTES];
    bit              slot_known [CTX_BYTES];
    logic [ID_W-1:0] slot_id    [CTX_BYTES];
    logic            model_mode;

    t_verdict verdict_q[$];
    int       items_sent    = 0;
    int       results_seen  = 0;
    int       mismatches    = 0;
    int       flush_count   = 0;
    int       forward_count = 0;
    int       dead_count    = 0;
    int       cycle_count   = 0;
    bit       tx_gaps_on    = 1'b1;
    bit       rx_stalls_on  = 1'b1;
    int       rx_hold_req   = 0;

    context_load_forward_dead_store_table_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_block_first  (i_block_first),
        .i_op           (i_op),
        .i_is_volatile  (i_is_volatile),
        .i_is_branch    (i_is_branch),
        .i_offset       (i_offset),
        .i_value_id     (i_value_id),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_replace_load (o_replace_load),
        .o_forward_id   (o_forward_id),
        .o_store_dead   (o_store_dead)
    );

    // 4 ns clock, starting high so the first falling edge is well defined.
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, verdict_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    function automatic void clear_live();
        foreach (slot_live[k])
            slot_live[k] = 1'b0;
        flush_count++;
    endfunction

    // Applies one accepted item to the shadow table and returns its result. Offsets are
    // 12 bits wide, so every offset lies inside the table.
    function automatic t_verdict predict_instr(input logic bf, input logic [OP_W-1:0] op,
                                               input logic vol, input logic br,
                                               input logic [OFFSET_W-1:0] off,
                                               input logic [ID_W-1:0] id);
        t_verdict v;
        v = '0;
        if (bf)
            clear_live();
        if (model_mode == MODE_FWD) begin
            if (vol) begin
                clear_live();
            end else if (op == OP_LOAD) begin
                if (slot_live[off]) begin
                    v.replace_load = 1'b1;
                    v.forward_id   = slot_id[off];
                end else begin
                    slot_id[off]    = id;
                    slot_live[off]  = 1'b1;
                    slot_known[off] = 1'b1;
                end
            end else if (op == OP_STORE) begin
                slot_id[off]    = id;
                slot_live[off]  = 1'b1;
                slot_known[off] = 1'b1;
            end
        end else begin
            if (vol || br) begin
                clear_live();
            end else if (op == OP_STORE) begin
                if (slot_live[off])
                    v.store_dead = 1'b1;
                else
                    slot_live[off] = 1'b1;
            end
        end
        return v;
    endfunction

    // Offers one item, starting and ending at a falling edge; valid stays high on return.
    task automatic send_item(input logic bf, input logic [OP_W-1:0] op, input logic vol,
                             input logic br, input logic [OFFSET_W-1:0] off,
                             input logic [ID_W-1:0] id);
        int   gap;
        logic first;
        first = bf;
        // A forward load must never read an offset that was marked but never given an id.
        if (model_mode == MODE_FWD && !bf && !vol && op == OP_LOAD
            && slot_live[off] && !slot_known[off])
            first = 1'b1;
        gap = tx_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_block_first <= first;
        i_op          <= op;
        i_is_volatile <= vol;
        i_is_branch   <= br;
        i_offset      <= off;
        i_value_id    <= id;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        verdict_q.push_back(predict_instr(first, op, vol, br, off, id));
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_xfer(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Changes the pass mode while the block is idle and reads it back.
    task automatic set_pass_mode(input logic mode);
        logic [PDATA_W-1:0] rd;
        wait_idle();
        apb_xfer(1'b1, ADDR_PASS_MODE, PDATA_W'(mode), rd);
        model_mode = mode;
        @(negedge i_clk);
        apb_xfer(1'b0, ADDR_PASS_MODE, '0, rd);
        if (rd !== PDATA_W'(mode))
            flag_mismatch($sformatf("pass_mode read back %h, expected %0b", rd, mode));
    endtask

    // Forward mode: hits, misses, id extremes, unused op, volatile and branch handling.
    task automatic test_forward_rules();
        set_pass_mode(MODE_FWD);
        send_item(1'b1, OP_LOAD,   1'b0, 1'b0, 12'h000, 16'hFFFF);
        send_item(1'b0, OP_LOAD,   1'b0, 1'b0, 12'h000, 16'h1234);
        send_item(1'b0, OP_STORE,  1'b0, 1'b0, 12'hFFF, 16'h0000);
        send_item(1'b0, OP_LOAD,   1'b0, 1'b0, 12'hFFF, 16'hABCD);
        send_item(1'b0, OP_STORE,  1'b0, 1'b0, 12'hFFF, 16'hFFFF);
        send_item(1'b0, OP_UNUSED, 1'b0, 1'b0, 12'hFFF, 16'h0005);
        send_item(1'b0, OP_LOAD,   1'b0, 1'b0, 12'hFFF, 16'h0001);
        // Volatile wins over the load: the table is flushed and nothing recorded.
        send_item(1'b0, OP_LOAD,   1'b1, 1'b0, 12'h000, 16'h0099);
        send_item(1'b0, OP_LOAD,   1'b0, 1'b0, 12'h000, 16'h0042);
        // A branch is ignored in forward mode, so this load still forwards.
        send_item(1'b0, OP_LOAD,   1'b0, 1'b1, 12'h000, 16'h0077);
        send_item(1'b1, OP_LOAD,   1'b0, 1'b0, 12'h000, 16'h0007);
    endtask

    // Backward mode: marking, dead stores, loads ignored, branch and volatile flushes.
    task automatic test_backward_rules();
        set_pass_mode(MODE_BWD);
        send_item(1'b1, OP_STORE,  1'b0, 1'b0, 12'h800, 16'h1111);
        send_item(1'b0, OP_STORE,  1'b0, 1'b0, 12'h800, 16'h2222);
        send_item(1'b0, OP_LOAD,   1'b0, 1'b0, 12'h7FF, 16'h3333);
        send_item(1'b0, OP_STORE,  1'b0, 1'b1, 12'h800, 16'h4444);
        send_item(1'b0, OP_STORE,  1'b0, 1'b0, 12'h800, 16'h5555);
        send_item(1'b0, OP_STORE,  1'b1, 1'b0, 12'h800, 16'h6666);
        send_item(1'b0, OP_UNUSED, 1'b0, 1'b0, 12'h800, 16'h7777);
        send_item(1'b1, OP_STORE,  1'b0, 1'b0, 12'h7FF, 16'h8888);
    endtask

    // A forward load finds an offset that backward mode marked within the same block.
    task automatic test_mode_crossing();
        set_pass_mode(MODE_FWD);
        send_item(1'b1, OP_STORE, 1'b0, 1'b0, 12'h555, 16'hBEEF);
        set_pass_mode(MODE_BWD);
        send_item(1'b1, OP_OTHER, 1'b0, 1'b0, 12'h555, 16'h0000);
        send_item(1'b0, OP_STORE, 1'b0, 1'b0, 12'h555, 16'hAAAA);
        set_pass_mode(MODE_FWD);
        send_item(1'b0, OP_LOAD,  1'b0, 1'b0, 12'h555, 16'hCAFE);
    endtask

    // The receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        set_pass_mode(MODE_FWD);
        tx_gaps_on  = 1'b0;
        rx_hold_req = 80;
        for (int k = 0; k < 24; k++)
            send_item(k == 0, (k % 2) ? OP_LOAD : OP_STORE, 1'b0, 1'b0,
                      OFFSET_W'(12'h100 + k % 4), ID_W'($urandom_range(0, 16'hFFFF)));
        tx_gaps_on = 1'b1;
        wait_idle();
    endtask

    // Phases of random blocks over a few hot offsets, with some noise items mixed in.
    task automatic test_random_stream();
        logic [OFFSET_W-1:0] hot [4];
        logic [OFFSET_W-1:0] off;
        logic [OP_W-1:0]     op;
        logic [ID_W-1:0]     id;
        logic                bf;
        logic                vol;
        logic                br;
        logic                opening;
        int                  start_count;
        int                  phase_len;
        int                  blk_left;
        int                  pick;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            set_pass_mode(1'($urandom_range(0, 1)));
            tx_gaps_on   = ($urandom_range(0, 4) != 0);
            rx_stalls_on = ($urandom_range(0, 4) != 0);
            foreach (hot[k])
                hot[k] = OFFSET_W'($urandom_range(0, CTX_BYTES - 1));
            phase_len = $urandom_range(40, 160);
            blk_left  = 0;
            opening   = 1'b0;
            for (int n = 0; n < phase_len; n++) begin
                if (blk_left == 0) begin
                    blk_left = $urandom_range(1, 12);
                    // Some blocks carry over the previous block's table on purpose.
                    opening  = ($urandom_range(0, 9) != 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    bf  = 1'($urandom_range(0, 1));
                    op  = OP_W'($urandom_range(0, 3));
                    vol = 1'($urandom_range(0, 1));
                    br  = 1'($urandom_range(0, 1));
                    off = OFFSET_W'($urandom_range(0, CTX_BYTES - 1));
                end else begin
                    bf      = opening;
                    opening = 1'b0;
                    pick    = $urandom_range(0, 99);
                    op      = (pick < 40) ? OP_LOAD : (pick < 80) ? OP_STORE :
                              (pick < 93) ? OP_OTHER : OP_UNUSED;
                    vol     = ($urandom_range(0, 24) == 0);
                    br      = ($urandom_range(0, 11) == 0);
                    off     = ($urandom_range(0, 4) != 0) ? hot[2'($urandom_range(0, 3))] :
                              OFFSET_W'($urandom_range(0, CTX_BYTES - 1));
                end
                id = ID_W'($urandom_range(0, 16'hFFFF));
                blk_left--;
                send_item(bf, op, vol, br, off, id);
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Result side: a random wait before each item, plus any long hold-off requested.
    initial begin : result_sink
        int wait_cycles;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            wait_cycles = rx_hold_req + (rx_stalls_on ? $urandom_range(0, 3) : 0);
            rx_hold_req = 0;
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid)
                @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Compares every accepted result item with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result replace=%0b fwd=%h dead=%0b",
                                        o_replace_load, o_forward_id, o_store_dead));
            end else begin
                want = verdict_q.pop_front();
                forward_count += want.replace_load;
                dead_count    += want.store_dead;
                if (o_replace_load !== want.replace_load
                    || o_forward_id !== want.forward_id
                    || o_store_dead !== want.store_dead)
                    flag_mismatch($sformatf(
                        "result %0d: expected replace=%0b fwd=%h dead=%0b, got %0b %h %0b",
                        results_seen, want.replace_load, want.forward_id, want.store_dead,
                        o_replace_load, o_forward_id, o_store_dead));
            end
        end
    end

    // Test sequence.
    initial begin : stimulus
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_in_valid    = 1'b0;
        i_block_first = 1'b0;
        i_op          = OP_OTHER;
        i_is_volatile = 1'b0;
        i_is_branch   = 1'b0;
        i_offset      = '0;
        i_value_id    = '0;
        model_mode    = MODE_FWD;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_forward_rules();
        test_backward_rules();
        test_mode_crossing();
        test_output_backpressure();
        test_random_stream();
        wait_idle();

        $display("Ran %0d items in both pass modes; %0d results checked, %0d loads forwarded,",
                 items_sent, results_seen, forward_count);
        $display("%0d stores found dead, %0d table flushes, %0d mismatches.",
                 dead_count, flush_count, mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
